/* rtl/rpwu_pkg.sv */
// Shared types and constants for the Rprop weight update block.
// Used by the controller, the datapath and the top level; no dependencies.
package rpwu_pkg;

  localparam int IDX_W    = 10;
  localparam int WEIGHT_W = 32;
  localparam int STEP_W   = 32;
  localparam int FACTOR_W = 16;
  localparam int SIGN_W   = 2;
  localparam int PROD_W   = FACTOR_W + STEP_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W = 80;
  localparam int OUT_DATA_W = 48;

  localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'd0;
  localparam logic [SIGN_W-1:0] SIGN_POS  = 2'd1;
  localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_INCREASE_FACTOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECREASE_FACTOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_MAX        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_MIN        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELATIVE_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_STEP    = 3'd5;

  typedef struct packed {
    logic capture;
    logic read;
    logic mul_ceil;
    logic mul_step;
    logic new_step;
    logic write_back;
  } rpwu_cmd_t;

  typedef struct packed {
    logic out_free;
  } rpwu_status_t;

endpackage

/* rtl/rpwu_ctrl.sv */
// Sequencer for the Rprop weight update: walks one word through read,
// two multiply steps, step update and write back. Depends on rpwu_pkg.
module rpwu_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  rpwu_pkg::rpwu_status_t status,
  output rpwu_pkg::rpwu_cmd_t   cmd
);
  import rpwu_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_READ     = 6'b000010,
    S_MUL_CEIL = 6'b000100,
    S_MUL_STEP = 6'b001000,
    S_NEW_STEP = 6'b010000,
    S_WB       = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.read = 1'b1;
        state_nxt = S_MUL_CEIL;
      end
      S_MUL_CEIL: begin
        cmd.mul_ceil = 1'b1;
        state_nxt = S_MUL_STEP;
      end
      S_MUL_STEP: begin
        cmd.mul_step = 1'b1;
        state_nxt = S_NEW_STEP;
      end
      S_NEW_STEP: begin
        cmd.new_step = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        // hold until the output register can take the word
        if (status.out_free) begin
          cmd.write_back = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/rpwu_datapath.sv */
// Datapath of the Rprop weight update: configuration registers, the
// step/sign memory, a shared 16x32 multiplier and the output register.
// Depends on rpwu_pkg; driven by rpwu_ctrl.
module rpwu_datapath #(
  parameter int NUM_ENTRIES = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rpwu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rpwu_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [rpwu_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                             in_tuser,
  input  rpwu_pkg::rpwu_cmd_t              cmd,
  output rpwu_pkg::rpwu_status_t           status,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rpwu_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import rpwu_pkg::*;

  localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int MEM_W = STEP_W + SIGN_W;
  localparam int RANGE_W = 17;

  function automatic logic [STEP_W-1:0] sat_q12(input logic [PROD_W-1:0] p);
    if (p[PROD_W-1:STEP_W+12] != '0) begin
      sat_q12 = '1;
    end else begin
      sat_q12 = p[STEP_W+11:12];
    end
  endfunction

  logic [FACTOR_W-1:0] inc_factor_r, dec_factor_r, rel_limit_r;
  logic [STEP_W-1:0]   step_max_r, step_min_r, init_step_r;

  logic [MEM_W-1:0]    mem [NUM_ENTRIES];
  logic [MEM_W-1:0]    rd_r;

  logic [IDX_W-1:0]    idx_r;
  logic [WEIGHT_W-1:0] w_r;
  logic [WEIGHT_W-1:0] grad_r;
  logic                first_r;
  logic                in_range_r;
  logic [STEP_W-1:0]   step_r;
  logic [SIGN_W-1:0]   last_r;
  logic [PROD_W-1:0]   prod_r;
  logic [STEP_W-1:0]   ceil_r;
  logic [STEP_W-1:0]   new_step_r;
  logic [SIGN_W-1:0]   new_sign_r;

  logic                out_valid_r;
  logic [IDX_W-1:0]    out_idx_r;
  logic [WEIGHT_W-1:0] out_w_r;

  logic [SIGN_W-1:0]   cur_sign;
  logic                same_sign, opp_sign;
  logic [STEP_W-1:0]   abs_w;
  logic [STEP_W-1:0]   scaled;
  logic [STEP_W-1:0]   ceil_sel;
  logic [STEP_W-1:0]   step_sel;
  logic [SIGN_W-1:0]   last_sel;
  logic [WEIGHT_W+1:0] w_ext, nw;
  logic [WEIGHT_W-1:0] nw_sat;
  logic [AW-1:0]       addr;

  assign addr = AW'(idx_r);

  assign cur_sign  = grad_r[WEIGHT_W-1] ? SIGN_NEG : ((grad_r != '0) ? SIGN_POS : SIGN_ZERO);
  assign same_sign = (cur_sign != SIGN_ZERO) && (last_r != SIGN_ZERO) && (cur_sign == last_r);
  assign opp_sign  = (cur_sign != SIGN_ZERO) && (last_r != SIGN_ZERO) && (cur_sign != last_r);
  assign abs_w     = w_r[WEIGHT_W-1] ? (~w_r + 1'b1) : w_r;
  assign scaled    = sat_q12(prod_r);
  assign ceil_sel  = (rel_limit_r != '0) ? ceil_r : step_max_r;
  assign step_sel  = first_r ? init_step_r : rd_r[STEP_W-1:0];
  assign last_sel  = (first_r || ((rd_r[MEM_W-1:STEP_W] != SIGN_POS) &&
                                  (rd_r[MEM_W-1:STEP_W] != SIGN_NEG))) ? SIGN_ZERO
                                                                       : rd_r[MEM_W-1:STEP_W];

  always_comb begin
    w_ext = {w_r[WEIGHT_W-1], w_r[WEIGHT_W-1], w_r};
    if (cur_sign == SIGN_POS) begin
      nw = w_ext - {2'b00, new_step_r};
    end else if (cur_sign == SIGN_NEG) begin
      nw = w_ext + {2'b00, new_step_r};
    end else begin
      nw = w_ext;
    end
    if (nw[WEIGHT_W+1:WEIGHT_W-1] == 3'b000 || nw[WEIGHT_W+1:WEIGHT_W-1] == 3'b111) begin
      nw_sat = nw[WEIGHT_W-1:0];
    end else if (nw[WEIGHT_W+1]) begin
      nw_sat = {1'b1, {(WEIGHT_W-1){1'b0}}};
    end else begin
      nw_sat = {1'b0, {(WEIGHT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_factor_r <= 16'd4915;
      dec_factor_r <= 16'd1352;
      step_max_r   <= 32'd3276800;
      step_min_r   <= 32'd1;
      rel_limit_r  <= 16'd0;
      init_step_r  <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INCREASE_FACTOR: inc_factor_r <= cfg_wdata[FACTOR_W-1:0];
        REG_DECREASE_FACTOR: dec_factor_r <= cfg_wdata[FACTOR_W-1:0];
        REG_STEP_MAX:        step_max_r   <= cfg_wdata[STEP_W-1:0];
        REG_STEP_MIN:        step_min_r   <= cfg_wdata[STEP_W-1:0];
        REG_RELATIVE_LIMIT:  rel_limit_r  <= cfg_wdata[FACTOR_W-1:0];
        REG_INITIAL_STEP:    init_step_r  <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r      <= in_tdata[IDX_W-1:0];
      w_r        <= in_tdata[IDX_W+WEIGHT_W-1:IDX_W];
      grad_r     <= in_tdata[IDX_W+2*WEIGHT_W-1:IDX_W+WEIGHT_W];
      first_r    <= in_tuser;
      in_range_r <= {{(RANGE_W-IDX_W){1'b0}}, in_tdata[IDX_W-1:0]} < RANGE_W'(NUM_ENTRIES);
    end
    if (cmd.read) begin
      rd_r <= mem[addr];
    end
    if (cmd.mul_ceil) begin
      step_r <= step_sel;
      last_r <= last_sel;
      prod_r <= rel_limit_r * abs_w;
    end
    if (cmd.mul_step) begin
      ceil_r <= scaled;
      prod_r <= (same_sign ? inc_factor_r : dec_factor_r) * step_r;
    end
    if (cmd.new_step) begin
      if (same_sign) begin
        new_step_r <= (scaled < ceil_sel) ? scaled : ceil_sel;
        new_sign_r <= cur_sign;
      end else if (opp_sign) begin
        new_step_r <= (scaled > step_min_r) ? scaled : step_min_r;
        new_sign_r <= SIGN_ZERO;
      end else begin
        new_step_r <= step_r;
        new_sign_r <= cur_sign;
      end
    end
    if (cmd.write_back && in_range_r) begin
      mem[addr] <= {new_sign_r, new_step_r};
    end
    if (cmd.write_back) begin
      out_idx_r <= idx_r;
      out_w_r   <= in_range_r ? nw_sat : w_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.write_back) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.out_free = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-IDX_W-WEIGHT_W){1'b0}}, out_w_r, out_idx_r};

endmodule

/* rtl/rprop_weight_update.sv */
// Top level of the Rprop weight update block: controller plus datapath.
// Depends on rpwu_pkg, rpwu_ctrl and rpwu_datapath.
//
// Each input word carries one parameter (index, weight, gradient, first-pass
// flag) and yields one output word with the index and the updated, saturated
// weight. On its way to the result register a word goes through one memory
// read, two passes through the shared 16x32 multiplier (ceiling, then step
// scaling), step selection and write back. The controller returns to idle
// only after write back, so a new word is not taken before the previous one
// is written back; write back waits while the previous result still sits
// unread in the output register.
// The step/sign memory holds no reset contents; an entry must be started
// with the first-pass flag before it is used without it.
module rprop_weight_update #(
  parameter int NUM_ENTRIES = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rpwu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rpwu_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // element_index[9:0], weight_in[41:10], gradient[73:42], zero fill
  input  logic [rpwu_pkg::IN_DATA_W-1:0]   in_tdata,
  // first_pass[0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // result_index[9:0], weight_out[41:10], zero fill
  output logic [rpwu_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import rpwu_pkg::*;

  rpwu_cmd_t    cmd;
  rpwu_status_t status;

  rpwu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  rpwu_datapath #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* bench/tb.sv */
// Self-checking bench for rprop_weight_update: stream driver, result monitor and a
// per-entry Rprop predictor with its own step and sign memories.
// Depends on rpwu_pkg and the rprop_weight_update RTL.
`timescale 1ns / 100ps

module tb;
  import rpwu_pkg::*;

  localparam int ENTRIES = 1024;
  localparam logic signed [33:0] WEIGHT_HI = 34'sh07FFFFFFF;
  localparam logic signed [33:0] WEIGHT_LO = -34'sh080000000;

  typedef struct packed {
    logic [IDX_W-1:0]    idx;
    logic [WEIGHT_W-1:0] weight;
    logic [WEIGHT_W-1:0] grad;
    logic                first;
  } param_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]    idx;
    logic [WEIGHT_W-1:0] weight;
  } update_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  rprop_weight_update #(.NUM_ENTRIES(ENTRIES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // predictor copy of the registers and the per-entry state
  logic [FACTOR_W-1:0] inc_factor   = 16'd4915;
  logic [FACTOR_W-1:0] dec_factor   = 16'd1352;
  logic [STEP_W-1:0]   step_ceiling = 32'd3276800;
  logic [STEP_W-1:0]   step_floor   = 32'd1;
  logic [FACTOR_W-1:0] rel_limit    = 16'd0;
  logic [STEP_W-1:0]   first_step   = 32'd65536;
  logic [STEP_W-1:0]   step_mem [ENTRIES];
  logic [SIGN_W-1:0]   sign_mem [ENTRIES];
  bit                  seeded [ENTRIES];

  param_word_t pending_words[$];
  update_t     expected_updates[$];
  param_word_t cur_word;
  update_t     want;
  logic [IDX_W-1:0]    got_idx;
  logic [WEIGHT_W-1:0] got_weight;

  int send_idle_pct = 14;
  int recv_idle_pct = 70;
  int errors = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_grown = 0;
  int n_capped = 0;
  int n_shrunk = 0;
  int n_held = 0;
  int n_saturated = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [STEP_W-1:0] scale_q12(input logic [FACTOR_W-1:0] f,
                                                  input logic [STEP_W-1:0] v);
    logic [PROD_W-1:0] p;
    p = {{STEP_W{1'b0}}, f} * {{FACTOR_W{1'b0}}, v};
    return (p[PROD_W-1:STEP_W+12] != '0) ? '1 : p[STEP_W+11:12];
  endfunction

  task automatic rprop_predict(input param_word_t wd);
    logic [STEP_W-1:0] step, ceiling, grown, shrunk, mag;
    logic [SIGN_W-1:0] last, cur, nsign;
    logic signed [33:0] nw;
    update_t r;
    step = wd.first ? first_step : step_mem[wd.idx];
    last = wd.first ? SIGN_ZERO : sign_mem[wd.idx];
    if (last != SIGN_POS && last != SIGN_NEG) last = SIGN_ZERO;
    cur = wd.grad[31] ? SIGN_NEG : ((wd.grad != '0) ? SIGN_POS : SIGN_ZERO);
    nsign = cur;
    if (cur != SIGN_ZERO && last != SIGN_ZERO && cur == last) begin
      ceiling = step_ceiling;
      if (rel_limit != '0) begin
        mag = wd.weight[31] ? -wd.weight : wd.weight;
        ceiling = scale_q12(rel_limit, mag);
      end
      grown = scale_q12(inc_factor, step);
      if (grown < ceiling) begin
        step = grown;
      end else begin
        step = ceiling;
        n_capped++;
      end
      n_grown++;
    end else if (cur != SIGN_ZERO && last != SIGN_ZERO) begin
      shrunk = scale_q12(dec_factor, step);
      step = (shrunk > step_floor) ? shrunk : step_floor;
      nsign = SIGN_ZERO;
      n_shrunk++;
    end else begin
      n_held++;
    end
    nw = {{2{wd.weight[31]}}, wd.weight};
    if (cur == SIGN_POS) nw = nw - $signed({2'b00, step});
    else if (cur == SIGN_NEG) nw = nw + $signed({2'b00, step});
    if (nw > WEIGHT_HI) begin
      nw = WEIGHT_HI;
      n_saturated++;
    end else if (nw < WEIGHT_LO) begin
      nw = WEIGHT_LO;
      n_saturated++;
    end
    step_mem[wd.idx] = step;
    sign_mem[wd.idx] = nsign;
    r.idx = wd.idx;
    r.weight = nw[31:0];
    expected_updates.push_back(r);
  endtask

  // driver: hold the word until taken, then advance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        rprop_predict(cur_word);
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_word = pending_words.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {{(IN_DATA_W-74){1'b0}}, cur_word.grad, cur_word.weight, cur_word.idx};
          in_tuser <= cur_word.first;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_tvalid && out_tready) begin
        got_idx = out_tdata[9:0];
        got_weight = out_tdata[41:10];
        n_checked++;
        if (expected_updates.size() == 0) begin
          $display("%0t: unexpected word idx=%0d weight=%h", $time, got_idx, got_weight);
          errors++;
        end else begin
          want = expected_updates.pop_front();
          if (got_idx !== want.idx) begin
            $display("%0t: result_index expected %0d got %0d", $time, want.idx, got_idx);
            errors++;
          end
          if (got_weight !== want.weight) begin
            $display("%0t: weight_out idx=%0d expected %h got %h",
                     $time, want.idx, want.weight, got_weight);
            errors++;
          end
        end
      end
    end
  end

  task automatic push_word(input logic [IDX_W-1:0] idx, input logic [31:0] w,
                           input logic [31:0] g, input logic first);
    param_word_t wd;
    wd.idx = idx;
    wd.weight = w;
    wd.grad = g;
    wd.first = first | !seeded[idx];
    seeded[idx] = 1'b1;
    pending_words.push_back(wd);
  endtask

  // most words hit a small pool of entries so updates chain back to back
  task automatic gen_random_words(input int count, input int pool, input int keep_pct);
    logic [IDX_W-1:0] idx;
    logic [31:0] w, g, mag;
    logic neg;
    int sel, form;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 80) idx = IDX_W'($urandom_range(pool - 1));
      else idx = IDX_W'($urandom);
      case ($urandom_range(4))
        0, 1: w = $urandom;
        2: begin
          w = $urandom_range(0, 32'h3FFFF);
          if ($urandom_range(1)) w = -w;
        end
        3: w = 32'h7FFFFFFF - $urandom_range(0, 255);
        default: w = 32'h80000000 + $urandom_range(0, 255);
      endcase
      sel = $urandom_range(99);
      neg = (sel < 6 + keep_pct) ? idx[0] : !idx[0];
      form = $urandom_range(3);
      case (form)
        0: mag = $urandom_range(1, 255);
        3: mag = 32'h7FFFFFFF;
        default: begin
          mag = $urandom & 32'h7FFFFFFF;
          if (mag == '0) mag = 32'd1;
        end
      endcase
      g = neg ? -mag : mag;
      if (neg && form == 3 && $urandom_range(1)) g = 32'h80000000;
      if (sel < 6) g = '0;
      push_word(idx, w, g, $urandom_range(99) < 6);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_INCREASE_FACTOR: inc_factor = val[15:0];
      REG_DECREASE_FACTOR: dec_factor = val[15:0];
      REG_STEP_MAX:        step_ceiling = val;
      REG_STEP_MIN:        step_floor = val;
      REG_RELATIVE_LIMIT:  rel_limit = val[15:0];
      REG_INITIAL_STEP:    first_step = val;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_tvalid || expected_updates.size() > 0)
      @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  initial begin
    int waited;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // grow, shrink, hold, zero gradient, restart and saturation at both ends
    push_word(10'd0, 32'h00000000, 32'h00000001, 1'b1);
    push_word(10'd0, 32'h00010000, 32'h12345678, 1'b0);
    push_word(10'd0, 32'h00020000, 32'h7FFFFFFF, 1'b0);
    push_word(10'd0, 32'h00030000, 32'hFFFFFFFF, 1'b0);
    push_word(10'd0, 32'h00030000, 32'h80000000, 1'b0);
    push_word(10'd0, 32'h00040000, 32'h00000000, 1'b0);
    push_word(10'd0, 32'h00040000, 32'h00000100, 1'b0);
    push_word(10'd1023, 32'h7FFFFFFF, 32'h80000000, 1'b1);
    push_word(10'd1023, 32'h80000000, 32'h7FFFFFFF, 1'b0);
    push_word(10'd512, 32'h80000000, 32'h00000001, 1'b1);
    push_word(10'd512, 32'h80000001, 32'h00000002, 1'b0);
    push_word(10'd0, 32'h12345678, 32'h00000000, 1'b1);
    push_word(10'd5, 32'hFFFF0000, 32'hFFFFFFFF, 1'b1);
    push_word(10'd5, 32'hFFFF0000, 32'hFFFFFFFB, 1'b0);
    push_word(10'd5, 32'hFFFF0000, 32'hFFFFFFFB, 1'b1);
    push_word(10'd5, 32'hFFFF0000, 32'h00000007, 1'b0);
    gen_random_words(140, 4, 90);
    gen_random_words(140, 64, 55);
    drain();

    write_reg(REG_INCREASE_FACTOR, 32'h0000FFFF);
    write_reg(REG_DECREASE_FACTOR, 32'h00000000);
    write_reg(REG_STEP_MAX, 32'hFFFFFFFF);
    write_reg(REG_STEP_MIN, 32'h00000000);
    write_reg(REG_RELATIVE_LIMIT, 32'h00000000);
    write_reg(REG_INITIAL_STEP, 32'hFFFFFFFF);
    end_writes();
    gen_random_words(270, 16, 70);
    drain();

    send_idle_pct = 70;
    recv_idle_pct = 14;
    write_reg(REG_INCREASE_FACTOR, 32'h00000000);
    write_reg(REG_DECREASE_FACTOR, 32'h0000FFFF);
    write_reg(REG_STEP_MAX, 32'h00000000);
    write_reg(REG_STEP_MIN, 32'hFFFFFFFF);
    write_reg(REG_RELATIVE_LIMIT, 32'h0000FFFF);
    write_reg(REG_INITIAL_STEP, 32'h00000000);
    end_writes();
    gen_random_words(270, 16, 60);
    drain();

    write_reg(REG_INCREASE_FACTOR, 32'd6144);
    write_reg(REG_DECREASE_FACTOR, 32'd2048);
    write_reg(REG_STEP_MAX, 32'h00100000);
    write_reg(REG_STEP_MIN, 32'd16);
    write_reg(REG_RELATIVE_LIMIT, 32'd1);
    write_reg(REG_INITIAL_STEP, 32'h00008000);
    end_writes();
    // relative ceiling from a tiny and a zero weight
    push_word(10'd20, 32'h00010000, 32'h00000040, 1'b1);
    push_word(10'd20, 32'h00001000, 32'h00000040, 1'b0);
    push_word(10'd20, 32'h00000000, 32'h00000040, 1'b0);
    push_word(10'd20, 32'h80000000, 32'h00000040, 1'b0);
    gen_random_words(270, 8, 85);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_INCREASE_FACTOR, $urandom_range(4096, 65535));
    write_reg(REG_DECREASE_FACTOR, $urandom_range(0, 4096));
    write_reg(REG_STEP_MAX, $urandom);
    write_reg(REG_STEP_MIN, $urandom_range(0, 32'h0000FFFF));
    write_reg(REG_RELATIVE_LIMIT, $urandom_range(0, 65535));
    write_reg(REG_INITIAL_STEP, $urandom_range(1, 32'h00100000));
    end_writes();
    gen_random_words(270, 32, 75);

    waited = 0;
    while ((pending_words.size() > 0 || in_tvalid || expected_updates.size() > 0)
           && waited < 50000) begin
      @(negedge clk);
      waited++;
    end
    repeat (20) @(negedge clk);
    if (pending_words.size() > 0 || expected_updates.size() > 0) begin
      $display("%0t: %0d words never taken, %0d results never arrived",
               $time, pending_words.size(), expected_updates.size());
      errors++;
    end

    $display("Sent %0d parameter words and checked %0d updates over five register settings",
             n_accepted, n_checked);
    $display("Steps grown %0d (%0d at ceiling), shrunk %0d, held %0d; weights saturated %0d",
             n_grown, n_capped, n_shrunk, n_held, n_saturated);
    if (errors == 0) begin
      $display("** rprop_weight_update: PASSED **");
    end else begin
      $display("** rprop_weight_update: FAILED **");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Run timed out");
    $display("** rprop_weight_update: FAILED **");
    $finish;
  end

endmodule
